// ===== rtl/core/bitmap_run_allocator_unit_macros.svh =====
// Assertion macros for the allocator RTL.
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRU_ASSERT_NOW(lbl, ante, cons, msg)
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/bru_pkg.sv =====
package bru_pkg;

  localparam int unsigned LEN_W = 6;
  localparam int unsigned END_W = 5;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [LEN_W-1:0] run_length;
    logic [END_W-1:0] free_end;
  } bru_in_t;

  typedef struct packed {
    logic             success;
    logic [END_W-1:0] end_index;
  } bru_out_t;

  // Probe wave moving up the cell row: free-run count below the cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [LEN_W-1:0] count;
  } fwd_t;

  // Mark wave moving down the cell row: blocks still to set or clear.
  typedef struct packed {
    logic             valid;
    logic             set;
    logic [LEN_W-1:0] rem;
  } bwd_t;

  // Request held by the controller and broadcast to every cell.
  typedef struct packed {
    cmd_e             cmd;
    logic [LEN_W-1:0] run_length;
    logic [LEN_W-1:0] free_rem;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/core/bru_cell.sv =====
module bru_cell import bru_pkg::*; #(
  parameter int unsigned IdxW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic [IdxW-1:0] start_pos_i,
  input  fwd_t            fwd_i,
  input  logic [IdxW-1:0] pos_i,
  output fwd_t            fwd_o,
  output logic [IdxW-1:0] pos_o,
  input  bwd_t            bwd_i,
  output bwd_t            bwd_o
);

  logic            occ_q, occ_d;
  fwd_t            fwd_q, fwd_d;
  logic [IdxW-1:0] pos_q, pos_d;
  bwd_t            bwd_q, bwd_d;

  logic             hit;
  logic [LEN_W-1:0] count_inc;
  logic             act_on;
  logic             act_set;
  logic [LEN_W-1:0] act_rem;

  always_comb begin
    count_inc = LEN_W'(fwd_i.count + 1'b1);
    if (cmd_i.cmd == CMD_ALLOC) begin
      hit = fwd_i.valid && !fwd_i.found && !occ_q &&
            (cmd_i.run_length != '0) && (count_inc == cmd_i.run_length);
    end else begin
      hit = fwd_i.valid && !fwd_i.found && (pos_i == start_pos_i);
    end

    // A run starts at this cell, or the mark wave arrives from above
    if (hit) begin
      act_on  = 1'b1;
      act_set = (cmd_i.cmd == CMD_ALLOC);
      act_rem = (cmd_i.cmd == CMD_ALLOC) ? cmd_i.run_length : cmd_i.free_rem;
    end else begin
      act_on  = bwd_i.valid;
      act_set = bwd_i.set;
      act_rem = bwd_i.rem;
    end

    occ_d = occ_q;
    bwd_d = '0;
    if (act_on && (act_rem != '0)) begin
      occ_d       = act_set;
      bwd_d.valid = 1'b1;
      bwd_d.set   = act_set;
      bwd_d.rem   = LEN_W'(act_rem - 1'b1);
    end

    fwd_d.valid = fwd_i.valid;
    fwd_d.found = fwd_i.found || hit;
    fwd_d.count = occ_q ? '0 : count_inc;
    // Freeze the position once found so it reaches the end as the run's index
    pos_d = fwd_d.found ? pos_i : IdxW'(pos_i + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      fwd_q <= '0;
      pos_q <= '0;
      bwd_q <= '0;
    end else begin
      occ_q <= occ_d;
      fwd_q <= fwd_d;
      pos_q <= pos_d;
      bwd_q <= bwd_d;
    end
  end

  assign fwd_o = fwd_q;
  assign pos_o = pos_q;
  assign bwd_o = bwd_q;

endmodule

// ===== rtl/core/bru_ctrl.sv =====
module bru_ctrl import bru_pkg::*; #(
  parameter int unsigned NumBlocks = 32,
  parameter int unsigned IdxW      = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bru_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bru_out_t        out_data_o,
  output cell_cmd_t       cmd_o,
  output logic [IdxW-1:0] start_pos_o,
  output fwd_t            launch_o,
  input  fwd_t            exit_i,
  input  logic [IdxW-1:0] exit_pos_i
);

  localparam int unsigned XW = ((IdxW > END_W) ? IdxW : END_W) + 1;

  state_e           state_q, state_d;
  cell_cmd_t        cmd_q, cmd_d;
  logic [IdxW-1:0]  start_q, start_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  bru_out_t         res_q, res_d;

  logic [XW-1:0] fe_x;
  logic [XW-1:0] last_x;
  logic [XW-1:0] skip_x;
  logic [XW-1:0] len_x;

  always_comb begin
    // Clip a free that starts above the top block; drop the blocks above it
    fe_x   = XW'(in_data_i.free_end);
    last_x = XW'(NumBlocks - 1);
    skip_x = XW'(fe_x - last_x);
    len_x  = XW'(in_data_i.run_length);

    state_d     = state_q;
    cmd_d       = cmd_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    launch_o    = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d.cmd        = in_data_i.cmd;
          cmd_d.run_length = in_data_i.run_length;
          if (fe_x > last_x) begin
            start_d        = IdxW'(last_x);
            cmd_d.free_rem = (len_x > skip_x) ? LEN_W'(len_x - skip_x) : '0;
          end else begin
            start_d        = IdxW'(fe_x);
            cmd_d.free_rem = in_data_i.run_length;
          end
          cnt_d   = in_data_i.run_length;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        launch_o.valid = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        if (exit_i.valid) begin
          if (cmd_q.cmd == CMD_FREE) begin
            res_d.success   = 1'b1;
            res_d.end_index = '0;
          end else begin
            res_d.success   = exit_i.found;
            res_d.end_index = exit_i.found ? END_W'(exit_pos_i) : '0;
          end
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Hold until the mark wave has walked its full length
        if (cnt_q == '0) begin
          state_d = ST_RESP;
        end else begin
          cnt_d = LEN_W'(cnt_q - 1'b1);
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    start_q <= start_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  assign out_data_o  = res_q;
  assign cmd_o       = cmd_q;
  assign start_pos_o = start_q;

`include "bitmap_run_allocator_unit_macros.svh"

  `BRU_ASSERT_NOW(a_resp_blocks_input, out_valid_o, !in_ready_o, "input taken during response")
  `BRU_ASSERT_NOW(a_exit_in_scan, exit_i.valid, state_q == ST_SCAN, "probe exit outside scan")
  `BRU_ASSERT_NEXT(a_accept_launch, in_valid_i && in_ready_o, state_q == ST_LAUNCH, "no launch")
  `BRU_ASSERT_NOW(a_fail_zero_end, out_valid_o && !out_data_o.success, out_data_o.end_index == '0, "failed alloc with nonzero end")

endmodule

// ===== rtl/core/bitmap_run_allocator_unit.sv =====
// First-fit allocator of contiguous runs over a NUM_BLOCKS-bit occupancy map,
// all free after reset. The map lives in a row of cells, one bit each. An
// allocate sends a probe up the row that counts free blocks; the first cell
// where the count reaches run_length marks itself and starts a mark wave back
// down. A free starts the same kind of wave, clearing, at free_end. After its
// input transfer, each request passes through launch, the probe crossing the
// row, a drain while the mark wave settles, and the response, before the unit
// is ready for the next one. One request is in flight at a time; the result
// waits in a register until its output transfer. end_index carries the low 5
// bits of the index.
module bitmap_run_allocator_unit import bru_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bru_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bru_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(NUM_BLOCKS);

  cell_cmd_t       cell_cmd;
  logic [IdxW-1:0] start_pos;
  fwd_t            fwd_c [NUM_BLOCKS+1];
  logic [IdxW-1:0] pos_c [NUM_BLOCKS+1];
  bwd_t            bwd_c [NUM_BLOCKS+1];

  bru_ctrl #(
    .NumBlocks (NUM_BLOCKS),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cell_cmd),
    .start_pos_o (start_pos),
    .launch_o    (fwd_c[0]),
    .exit_i      (fwd_c[NUM_BLOCKS]),
    .exit_pos_i  (pos_c[NUM_BLOCKS])
  );

  // Probe enters at block 0; nothing enters the mark chain from the top
  assign pos_c[0]          = '0;
  assign bwd_c[NUM_BLOCKS] = '0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    bru_cell #(
      .IdxW (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cell_cmd),
      .start_pos_i (start_pos),
      .fwd_i       (fwd_c[g]),
      .pos_i       (pos_c[g]),
      .fwd_o       (fwd_c[g+1]),
      .pos_o       (pos_c[g+1]),
      .bwd_i       (bwd_c[g+1]),
      .bwd_o       (bwd_c[g])
    );
  end

endmodule
